/* rtl/core/rse_pkg.sv */
// Shared types, constants and field arithmetic for the Reed-Solomon encoder.
`default_nettype none

package rse_pkg;

    localparam int SYM_W     = 8;
    localparam int POLY_W    = 9;
    localparam int T_W       = 4;
    localparam int PAR_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_MODE = 2'd2;

    localparam logic MODE_SYSTEMATIC    = 1'b0;
    localparam logic MODE_NONSYSTEMATIC = 1'b1;

    localparam logic [POLY_W-1:0] RST_FIELD_POLY  = 9'd285;
    localparam logic [T_W-1:0]    RST_CORR_COUNT  = 4'd8;
    localparam logic              RST_ENCODE_MODE = MODE_SYSTEMATIC;

    localparam logic [SYM_W-1:0] ALPHA = 8'd2;

    typedef enum logic {
        ST_BUILD,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic              ok;
        logic              busy;
        logic              clear;
        logic              mode;
        logic [3:0]        sym_m;
        logic [POLY_W-1:0] poly;
        logic [PAR_W-1:0]  par_len;
        logic [SYM_W-1:0]  msg_len;
    } t_ctrl;

    function automatic logic [SYM_W-1:0] gf_mul(
        input logic [SYM_W-1:0]  a,
        input logic [SYM_W-1:0]  b,
        input logic [POLY_W-1:0] poly,
        input logic [3:0]        m
    );
        logic [POLY_W-1:0] aa;
        logic [POLY_W-1:0] top;
        logic [POLY_W-1:0] mask;
        logic [SYM_W-1:0]  acc;
        top  = POLY_W'(1) << m;
        mask = top - POLY_W'(1);
        aa   = {1'b0, a};
        acc  = '0;
        for (int i = 0; i < SYM_W; i++) begin
            if (i < int'(m)) begin
                if (b[i]) begin
                    acc = acc ^ aa[SYM_W-1:0];
                end
                aa = aa << 1;
                if ((aa & top) != '0) begin
                    aa = aa ^ poly;
                end
            end
        end
        return acc & mask[SYM_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/reed_solomon_encoder_top.sv */
// Top level of the Reed-Solomon encoder over GF(2^m).
//
//  channel   direction  handshake                     payload
//  -------   ---------  ---------                     -------
//  in        request    i_in_valid / o_in_ready       i_message_symbol
//  out       result     o_out_valid / i_out_ready     o_code_symbol, o_is_parity,
//                                                     o_block_last
//  cfg       write      i_cfg_we                      i_cfg_index, i_cfg_data
//
// One message symbol per cycle while o_in_ready is high; a request taken with valid
// settings is answered by one result the next cycle, set by the single parity
// register bank that updates all 2t stages at once; it shifts out at block end.
// After reset or a write to index 0, 1 or 2 the generator is built, one root per
// cycle, while o_in_ready stays low; when the settings are invalid no root is built.
// Reset is synchronous, active low; a stalled output holds its result while the
// next request waits in front of the output register.
`default_nettype none

module reed_solomon_encoder_top import rse_pkg::*; #(
    parameter int SYMBOL_BITS     = 8,
    parameter int MAX_CORRECTABLE = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [POLY_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [SYM_W-1:0]     i_message_symbol,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [SYM_W-1:0]          o_code_symbol,
    output logic                      o_is_parity,
    output logic                      o_block_last
);

    t_ctrl                  ctrl;
    logic [SYMBOL_BITS-1:0] gen [2*MAX_CORRECTABLE];

    rse_gen #(
        .SYMBOL_BITS     (SYMBOL_BITS),
        .MAX_CORRECTABLE (MAX_CORRECTABLE)
    ) u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctrl      (ctrl),
        .o_gen       (gen)
    );

    rse_core #(
        .SYMBOL_BITS     (SYMBOL_BITS),
        .MAX_CORRECTABLE (MAX_CORRECTABLE)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_gen            (gen),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_message_symbol (i_message_symbol),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_code_symbol    (o_code_symbol),
        .o_is_parity      (o_is_parity),
        .o_block_last     (o_block_last)
    );

endmodule

`default_nettype wire

/* rtl/core/rse_gen.sv */
// Configuration registers, derived block geometry and generator polynomial builder.
`default_nettype none

module rse_gen import rse_pkg::*; #(
    parameter int SYMBOL_BITS     = 8,
    parameter int MAX_CORRECTABLE = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [POLY_W-1:0]      i_cfg_data,
    output t_ctrl                       o_ctrl,
    output logic [SYMBOL_BITS-1:0]      o_gen [2*MAX_CORRECTABLE]
);

    localparam int P = 2 * MAX_CORRECTABLE;

    logic [POLY_W-1:0] r_poly;
    logic [T_W-1:0]    r_t;
    logic              r_mode;
    t_state            r_state;
    t_state            n_state;
    logic [PAR_W-1:0]  r_step;
    logic [SYM_W-1:0]  r_root;
    logic [SYM_W-1:0]  r_g [P+1];
    logic [SYM_W-1:0]  n_g [P+1];

    logic              cfg_hit;
    logic [3:0]        sym_m;
    logic [PAR_W-1:0]  par_len;
    logic [POLY_W-1:0] modulus;
    logic [POLY_W-1:0] msg_diff;
    logic              ok;
    logic              busy;
    logic              build_go;

    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_FIELD_POLY ||
                                  i_cfg_index == CFG_CORR_COUNT ||
                                  i_cfg_index == CFG_ENCODE_MODE);

    always_comb begin
        sym_m = '0;
        for (int d = 0; d < POLY_W; d++) begin
            if (r_poly[d]) begin
                sym_m = 4'(d);
            end
        end
    end

    assign par_len  = {r_t, 1'b0};
    assign modulus  = (POLY_W'(1) << sym_m) - POLY_W'(1);
    assign msg_diff = modulus - POLY_W'(par_len);
    assign ok = (sym_m >= 4'd3) && (int'(sym_m) <= SYMBOL_BITS) && (r_t != '0) &&
                (int'(r_t) <= MAX_CORRECTABLE) && (POLY_W'(par_len) < modulus);

    always_comb begin
        case (r_state)
            ST_BUILD: begin
                if (!ok || r_step == par_len) begin
                    n_state = ST_RUN;
                end else begin
                    n_state = ST_BUILD;
                end
            end
            ST_RUN:  n_state = ST_RUN;
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_BUILD: begin
                busy     = 1'b1;
                build_go = ok && (r_step != par_len);
            end
            default: begin
                busy     = 1'b0;
                build_go = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_g[0] = gf_mul(r_root, r_g[0], r_poly, sym_m);
        for (int j = 1; j <= P; j++) begin
            n_g[j] = r_g[j-1] ^ gf_mul(r_root, r_g[j], r_poly, sym_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly  <= RST_FIELD_POLY;
            r_t     <= RST_CORR_COUNT;
            r_mode  <= RST_ENCODE_MODE;
            r_state <= ST_BUILD;
            r_step  <= '0;
            r_root  <= ALPHA;
            for (int j = 0; j <= P; j++) begin
                r_g[j] <= (j == 0) ? SYM_W'(1) : '0;
            end
        end else if (cfg_hit) begin
            case (i_cfg_index)
                CFG_FIELD_POLY:  r_poly <= i_cfg_data;
                CFG_CORR_COUNT:  r_t    <= i_cfg_data[T_W-1:0];
                CFG_ENCODE_MODE: r_mode <= i_cfg_data[0];
                default:         r_mode <= r_mode;
            endcase
            r_state <= ST_BUILD;
            r_step  <= '0;
            r_root  <= ALPHA;
            for (int j = 0; j <= P; j++) begin
                r_g[j] <= (j == 0) ? SYM_W'(1) : '0;
            end
        end else begin
            r_state <= n_state;
            if (build_go) begin
                r_g    <= n_g;
                r_root <= gf_mul(r_root, ALPHA, r_poly, sym_m);
                r_step <= r_step + PAR_W'(1);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < P; j++) begin
            o_gen[j] = SYMBOL_BITS'(r_g[j]);
        end
    end

    always_comb begin
        o_ctrl.ok      = ok;
        o_ctrl.busy    = busy;
        o_ctrl.clear   = cfg_hit;
        o_ctrl.mode    = r_mode;
        o_ctrl.sym_m   = sym_m;
        o_ctrl.poly    = r_poly;
        o_ctrl.par_len = par_len;
        o_ctrl.msg_len = msg_diff[SYM_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/core/rse_core.sv */
// Parity register bank, symbol counter, parity flush and output register.
`default_nettype none

module rse_core import rse_pkg::*; #(
    parameter int SYMBOL_BITS     = 8,
    parameter int MAX_CORRECTABLE = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_ctrl                  i_ctrl,
    input  wire logic [SYMBOL_BITS-1:0] i_gen [2*MAX_CORRECTABLE],
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [SYM_W-1:0]       i_message_symbol,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [SYM_W-1:0]            o_code_symbol,
    output logic                        o_is_parity,
    output logic                        o_block_last
);

    localparam int P = 2 * MAX_CORRECTABLE;

    logic [SYMBOL_BITS-1:0] r_rem [P];
    logic [SYMBOL_BITS-1:0] n_rem [P];
    logic [SYM_W-1:0]       r_count;
    logic [PAR_W-1:0]       r_flush;
    logic                   r_out_valid;
    logic [SYMBOL_BITS-1:0] r_code;
    logic                   r_par;
    logic                   r_last;

    logic [POLY_W-1:0]      sym_mask;
    logic [SYMBOL_BITS-1:0] sym;
    logic [SYMBOL_BITS-1:0] top;
    logic [SYMBOL_BITS-1:0] fb;
    logic [SYMBOL_BITS-1:0] n_code;
    logic                   slot_free;
    logic                   in_fire;
    logic                   in_load;
    logic                   flush_go;
    logic                   is_last;

    assign sym_mask  = (POLY_W'(1) << i_ctrl.sym_m) - POLY_W'(1);
    assign sym       = SYMBOL_BITS'(i_message_symbol & sym_mask[SYM_W-1:0]);
    assign slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready = !i_ctrl.busy && (r_flush == '0) && slot_free;
    assign in_fire   = i_in_valid && o_in_ready;
    assign in_load   = in_fire && i_ctrl.ok;
    assign flush_go  = (r_flush != '0) && slot_free;
    assign is_last   = ({1'b0, r_count} + 9'd1) >= {1'b0, i_ctrl.msg_len};

    always_comb begin
        top = '0;
        for (int i = 0; i < P; i++) begin
            if ((i + 1) == int'(i_ctrl.par_len)) begin
                top = r_rem[i];
            end
        end
    end

    assign fb = (i_ctrl.mode == MODE_SYSTEMATIC) ? (sym ^ top) : sym;

    always_comb begin
        for (int i = 0; i < P; i++) begin
            n_rem[i] = (i == 0) ? '0 : r_rem[(i == 0) ? 0 : i - 1];
            if (!flush_go) begin
                n_rem[i] = n_rem[i] ^ SYMBOL_BITS'(gf_mul(SYM_W'(fb), SYM_W'(i_gen[i]),
                                                          i_ctrl.poly, i_ctrl.sym_m));
            end
        end
    end

    always_comb begin
        if (flush_go) begin
            n_code = top;
        end else if (i_ctrl.mode == MODE_SYSTEMATIC) begin
            n_code = sym;
        end else begin
            n_code = sym ^ top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int i = 0; i < P; i++) begin
                r_rem[i] <= '0;
            end
            r_count     <= '0;
            r_flush     <= '0;
            r_out_valid <= 1'b0;
        end else if (in_load || flush_go) begin
            r_rem       <= n_rem;
            r_out_valid <= 1'b1;
            r_code      <= n_code;
            r_par       <= flush_go && (i_ctrl.mode == MODE_SYSTEMATIC);
            r_last      <= flush_go && (r_flush == PAR_W'(1));
            if (flush_go) begin
                r_flush <= r_flush - PAR_W'(1);
            end else if (is_last) begin
                r_flush <= i_ctrl.par_len;
                r_count <= '0;
            end else begin
                r_count <= r_count + SYM_W'(1);
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_symbol = SYM_W'(r_code);
    assign o_is_parity   = r_par;
    assign o_block_last  = r_last;

    a_flush_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_load && is_last && !i_ctrl.clear |=> r_flush == $past(i_ctrl.par_len))
        else $error("parity flush did not start with full parity count");

    a_last_ends_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_flush == '0)
        else $error("codeword end shown while parity remains");

    a_flush_needs_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush != '0 |-> i_ctrl.ok && !i_ctrl.busy)
        else $error("parity flush pending without a valid built generator");

    a_flush_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush_go && r_flush == PAR_W'(1) && !i_ctrl.clear |=> top == '0)
        else $error("parity bank not empty after flush");

endmodule

`default_nettype wire

/* dv/tb_reed_solomon_encoder_top.sv */
// Testbench for the Reed-Solomon encoder: directed and random symbol streams checked per field.
`timescale 1ns / 1ps

module tb_reed_solomon_encoder_top;
    import rse_pkg::*;

    localparam int MAX_T = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CFG_SETTLE  = 40;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 150;
    localparam int ITEM_TARGET = 500;
    localparam int PRINT_CAP   = 100;
    localparam logic [POLY_W-1:0] FIELD_CHOICES [10] =
        '{9'd11, 9'd13, 9'd9, 9'd15, 9'd19, 9'd25, 9'd31, 9'd37, 9'd41, 9'd61};

    typedef enum logic [1:0] {
        OP_SYM,
        OP_CFG,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [POLY_W-1:0]    data;
        logic [SYM_W-1:0]     sym;
        logic [7:0]           gap;
    } t_stim_op;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             par;
        logic             last;
    } t_code;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [POLY_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic [SYM_W-1:0]     i_message_symbol = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [SYM_W-1:0]     o_code_symbol;
    logic                 o_is_parity;
    logic                 o_block_last;

    reed_solomon_encoder_top #(
        .SYMBOL_BITS(SYM_W),
        .MAX_CORRECTABLE(MAX_T)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_message_symbol(i_message_symbol),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_code_symbol(o_code_symbol),
        .o_is_parity(o_is_parity),
        .o_block_last(o_block_last)
    );

    always #2 i_clk = ~i_clk;

    logic [POLY_W-1:0] fld_poly;
    logic [T_W-1:0]    corr_t;
    logic              enc_mode;
    int unsigned       fld_deg;
    int unsigned       par_cnt;
    int unsigned       blk_len;
    int unsigned       blk_pos;
    logic [SYM_W-1:0]  gen_poly [0:2*MAX_T];
    logic [SYM_W-1:0]  parity_reg [0:2*MAX_T-1];
    logic [SYM_W-1:0]  tap_hist [0:2*MAX_T-1];

    t_code       expected_codes [$];
    t_stim_op    pending_ops [$];
    logic [POLY_W-1:0] plan_poly = RST_FIELD_POLY;
    logic [T_W-1:0]    plan_t = RST_CORR_COUNT;

    int unsigned mismatches = 0;
    int unsigned quiet_cnt = 0;
    int unsigned gap_left = 0;
    bit          gap_loaded = 1'b0;
    int unsigned syms_taken = 0;
    int unsigned hold_left = 0;
    int unsigned holds_done = 0;
    int unsigned hold_mark = 60;
    int unsigned stall_left = 0;
    int unsigned cycle_cnt = 0;

    function automatic int unsigned field_degree(logic [POLY_W-1:0] p);
        int unsigned d;
        int i;
        d = 0;
        for (i = 0; i < POLY_W; i++) begin
            if (p[i]) begin
                d = i;
            end
        end
        return d;
    endfunction

    function automatic int unsigned block_len(logic [POLY_W-1:0] p, logic [T_W-1:0] t);
        int unsigned d;
        int unsigned n;
        d = field_degree(p);
        n = (1 << d) - 1;
        if (d < 3 || d > SYM_W || t == 0 || t > MAX_T || 2 * t >= n) begin
            return 0;
        end
        return n - 2 * t;
    endfunction

    function automatic logic [SYM_W-1:0] gf_times(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b);
        logic [POLY_W-1:0] sh;
        logic [SYM_W-1:0]  prod;
        int i;
        sh = {1'b0, a};
        prod = '0;
        for (i = 0; i < fld_deg; i++) begin
            if (b[i]) begin
                prod ^= sh[SYM_W-1:0];
            end
            sh = sh << 1;
            if (sh[fld_deg]) begin
                sh ^= fld_poly;
            end
        end
        return prod;
    endfunction

    function automatic void rebuild_encoder();
        logic [SYM_W-1:0] root;
        int i;
        int j;
        fld_deg = field_degree(fld_poly);
        par_cnt = 2 * corr_t;
        blk_len = block_len(fld_poly, corr_t);
        blk_pos = 0;
        for (i = 0; i <= 2 * MAX_T; i++) begin
            gen_poly[i] = '0;
        end
        for (i = 0; i < 2 * MAX_T; i++) begin
            parity_reg[i] = '0;
            tap_hist[i] = '0;
        end
        if (blk_len == 0) begin
            return;
        end
        gen_poly[0] = 8'd1;
        root = 8'd1;
        for (i = 1; i <= par_cnt; i++) begin
            root = gf_times(root, ALPHA);
            for (j = i; j > 0; j--) begin
                gen_poly[j] = gen_poly[j-1] ^ gf_times(root, gen_poly[j]);
            end
            gen_poly[0] = gf_times(root, gen_poly[0]);
        end
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [POLY_W-1:0] data);
        case (idx)
            CFG_FIELD_POLY: begin
                fld_poly = data;
            end
            CFG_CORR_COUNT: begin
                corr_t = data[T_W-1:0];
            end
            CFG_ENCODE_MODE: begin
                enc_mode = data[0];
            end
            default: begin
                return;
            end
        endcase
        rebuild_encoder();
    endfunction

    function automatic void push_code(logic [SYM_W-1:0] s, logic p, logic l);
        expected_codes.insert(expected_codes.size(), t_code'{sym: s, par: p, last: l});
    endfunction

    function automatic logic [SYM_W-1:0] conv_step(logic [SYM_W-1:0] x);
        logic [SYM_W-1:0] acc;
        int l;
        acc = x;
        for (l = 1; l <= par_cnt; l++) begin
            acc ^= gf_times(gen_poly[par_cnt - l], tap_hist[l - 1]);
        end
        for (l = par_cnt - 1; l > 0; l--) begin
            tap_hist[l] = tap_hist[l - 1];
        end
        tap_hist[0] = x;
        return acc;
    endfunction

    function automatic void encode_symbol(logic [SYM_W-1:0] raw);
        logic [SYM_W-1:0] s;
        logic [SYM_W-1:0] fb;
        logic             done;
        int i;
        if (blk_len == 0) begin
            return;
        end
        s = raw & SYM_W'((1 << fld_deg) - 1);
        done = (blk_pos + 1 >= blk_len);
        if (enc_mode == MODE_SYSTEMATIC) begin
            fb = s ^ parity_reg[par_cnt - 1];
            for (i = par_cnt - 1; i > 0; i--) begin
                parity_reg[i] = parity_reg[i-1] ^ gf_times(fb, gen_poly[i]);
            end
            parity_reg[0] = gf_times(fb, gen_poly[0]);
            push_code(s, 1'b0, 1'b0);
            if (done) begin
                for (i = par_cnt; i > 0; i--) begin
                    push_code(parity_reg[i-1], 1'b1, i == 1);
                end
                for (i = 0; i < 2 * MAX_T; i++) begin
                    parity_reg[i] = '0;
                end
            end
        end else begin
            push_code(conv_step(s), 1'b0, 1'b0);
            if (done) begin
                for (i = 0; i < par_cnt; i++) begin
                    push_code(conv_step('0), 1'b0, i + 1 == par_cnt);
                end
                for (i = 0; i < 2 * MAX_T; i++) begin
                    tap_hist[i] = '0;
                end
            end
        end
        blk_pos = done ? 0 : ((blk_pos + 1) & 8'hFF);
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_symbol(logic [SYM_W-1:0] s, int unsigned gap);
        pending_ops.insert(pending_ops.size(),
                           t_stim_op'{kind: OP_SYM, idx: '0, data: '0, sym: s, gap: 8'(gap)});
    endtask

    task automatic queue_write(logic [CFG_IDX_W-1:0] idx, logic [POLY_W-1:0] data);
        pending_ops.insert(pending_ops.size(),
                           t_stim_op'{kind: OP_CFG, idx: idx, data: data, sym: '0, gap: '0});
        if (idx == CFG_FIELD_POLY) begin
            plan_poly = data;
        end else if (idx == CFG_CORR_COUNT) begin
            plan_t = data[T_W-1:0];
        end
    endtask

    task automatic queue_drain();
        pending_ops.insert(pending_ops.size(),
                           t_stim_op'{kind: OP_DRAIN, idx: '0, data: '0, sym: '0, gap: '0});
    endtask

    task automatic compare_field(string name, logic [SYM_W-1:0] want, logic [SYM_W-1:0] got);
        if (want !== got) begin
            if (mismatches < PRINT_CAP) begin
                $error("%s: expected %0h, got %0h", name, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic                 nxt_valid;
        logic                 nxt_we;
        logic [SYM_W-1:0]     nxt_sym;
        logic [CFG_IDX_W-1:0] nxt_idx;
        logic [POLY_W-1:0]    nxt_data;
        bit                   advance;
        nxt_valid = i_in_valid;
        nxt_sym = i_message_symbol;
        nxt_we = 1'b0;
        nxt_idx = i_cfg_index;
        nxt_data = i_cfg_data;
        advance = 1'b0;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            quiet_cnt = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                encode_symbol(i_message_symbol);
                syms_taken++;
                nxt_valid = 1'b0;
            end
            if (expected_codes.size() == 0 && !i_in_valid) begin
                quiet_cnt++;
            end else begin
                quiet_cnt = 0;
            end
            if (!nxt_valid && pending_ops.size() > 0) begin
                if (!gap_loaded) begin
                    gap_left = pending_ops[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    case (pending_ops[0].kind)
                        OP_SYM: begin
                            nxt_valid = 1'b1;
                            nxt_sym = pending_ops[0].sym;
                            advance = 1'b1;
                        end
                        OP_CFG: begin
                            if (quiet_cnt >= CFG_SETTLE) begin
                                nxt_we = 1'b1;
                                nxt_idx = pending_ops[0].idx;
                                nxt_data = pending_ops[0].data;
                                write_register(nxt_idx, nxt_data);
                                quiet_cnt = 0;
                                advance = 1'b1;
                            end
                        end
                        default: begin
                            advance = (expected_codes.size() == 0);
                        end
                    endcase
                    if (advance) begin
                        pending_ops.delete(0);
                        gap_loaded = 1'b0;
                    end
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_message_symbol <= nxt_sym;
        i_cfg_we <= nxt_we;
        i_cfg_index <= nxt_idx;
        i_cfg_data <= nxt_data;
    end

    always @(posedge i_clk) begin : monitor
        t_code want;
        logic  nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_codes.size() == 0) begin
                    if (mismatches < PRINT_CAP) begin
                        $error("unexpected code symbol %0h", o_code_symbol);
                    end
                    mismatches++;
                end else begin
                    want = expected_codes.pop_front();
                    compare_field("code_symbol", want.sym, o_code_symbol);
                    compare_field("is_parity", SYM_W'(want.par), SYM_W'(o_is_parity));
                    compare_field("block_last", SYM_W'(want.last), SYM_W'(o_block_last));
                end
            end
            cycle_cnt++;
            // hold off the output while requests keep coming, so the input backs up
            if (hold_left == 0 && holds_done < 2 && i_in_valid &&
                    expected_codes.size() > 0 && syms_taken >= hold_mark) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
                hold_mark += 250;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (((cycle_cnt / 800) % 3) != 0 && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(7, 29);
            end else begin
                nxt_ready = 1'b1;
            end
        end
        i_out_ready <= nxt_ready;
    end

    initial begin
        int unsigned items;
        int unsigned nblk;
        int unsigned len;
        int unsigned part;
        int unsigned deg;
        int unsigned tmax;
        int unsigned n;
        int unsigned b;
        logic [POLY_W-1:0] poly_pick;
        bit calm;
        bit big_done;

        fld_poly = RST_FIELD_POLY;
        corr_t = RST_CORR_COUNT;
        enc_mode = RST_ENCODE_MODE;
        rebuild_encoder();

        // reset settings, partial block dropped by the next write
        queue_symbol(8'h00, 0);
        queue_symbol(8'hFF, 0);
        queue_symbol(8'h80, 0);
        // invalid settings: zero t, oversized t, t too large for the field, field too narrow
        queue_write(CFG_CORR_COUNT, 9'h1F0);
        queue_symbol(8'h5A, 0);
        queue_write(CFG_FIELD_POLY, 9'h1FF);
        queue_write(CFG_CORR_COUNT, 9'h00F);
        queue_symbol(8'hA5, 0);
        queue_write(CFG_FIELD_POLY, 9'd11);
        queue_write(CFG_CORR_COUNT, 9'd4);
        queue_symbol(8'h3C, 0);
        queue_write(CFG_FIELD_POLY, 9'd5);
        queue_write(CFG_CORR_COUNT, 9'h1F1);
        queue_symbol(8'hC3, 0);
        // GF(8), t = 1: wide symbols lose their high bits
        queue_write(CFG_FIELD_POLY, 9'd11);
        queue_symbol(8'h07, 0);
        queue_symbol(8'hF8, 0);
        queue_symbol(8'h00, 0);
        queue_symbol(8'hFF, 0);
        queue_symbol(8'h3C, 0);
        // write to the spare index mid-block; the block carries on
        queue_symbol(8'h12, 0);
        queue_symbol(8'h6D, 0);
        queue_write(CFG_SPARE, 9'h1FF);
        queue_symbol(8'hE1, 3);
        queue_symbol(8'h9F, 0);
        queue_symbol(8'h44, 1);
        // product form, with a pause for every result mid-block
        queue_write(CFG_ENCODE_MODE, 9'h1FF);
        queue_symbol(8'hFF, 0);
        queue_symbol(8'h00, 0);
        queue_drain();
        queue_symbol(8'h07, 0);
        queue_symbol(8'h81, 0);
        queue_symbol(8'h5E, 0);
        // one message symbol per block
        queue_write(CFG_CORR_COUNT, 9'h003);
        queue_symbol(8'h07, 0);
        queue_symbol(8'h06, 0);
        queue_write(CFG_ENCODE_MODE, 9'h000);
        queue_symbol(8'h05, 0);
        queue_symbol(8'hFF, 0);

        items = 0;
        big_done = 1'b0;
        while (items < ITEM_TARGET) begin
            calm = ($urandom_range(0, 2) == 0);
            if (!big_done && items >= 150) begin
                big_done = 1'b1;
                queue_write(CFG_FIELD_POLY, RST_FIELD_POLY);
                queue_write(CFG_CORR_COUNT, {5'd0, RST_CORR_COUNT});
                queue_write(CFG_ENCODE_MODE, {8'd0, MODE_SYSTEMATIC});
            end else if ($urandom_range(0, 99) < 10) begin
                case ($urandom_range(0, 2))
                    0: queue_write(CFG_FIELD_POLY, POLY_W'($urandom_range(0, 7)));
                    1: queue_write(CFG_CORR_COUNT, {5'($urandom), 4'd0});
                    default: queue_write(CFG_CORR_COUNT,
                                         {5'($urandom), 4'($urandom_range(9, 15))});
                endcase
                for (n = 0; n < 3; n++) begin
                    queue_symbol(8'($urandom), pick_gap(calm));
                end
                continue;
            end else begin
                poly_pick = ($urandom_range(0, 99) < 6) ? 9'd67
                                                        : FIELD_CHOICES[$urandom_range(0, 9)];
                deg = field_degree(poly_pick);
                tmax = (deg == 3) ? 3 : (deg == 4) ? 7 : MAX_T;
                queue_write(CFG_FIELD_POLY, poly_pick);
                queue_write(CFG_CORR_COUNT, {5'($urandom), 4'($urandom_range(1, tmax))});
                if ($urandom_range(0, 1) == 1) begin
                    queue_write(CFG_ENCODE_MODE, {8'($urandom), 1'($urandom_range(0, 1))});
                end
            end
            len = block_len(plan_poly, plan_t);
            nblk = (len <= 20) ? $urandom_range(1, 4) : 1;
            for (b = 0; b < nblk; b++) begin
                for (n = 0; n < len; n++) begin
                    if (n > 0 && n == len / 2) begin
                        case ($urandom_range(0, 11))
                            0: queue_drain();
                            1: queue_write(CFG_SPARE, POLY_W'($urandom));
                            default: ;
                        endcase
                    end
                    queue_symbol(8'($urandom), pick_gap(calm));
                    items++;
                end
            end
            // leave a broken block for the next write to drop
            if (len > 1 && $urandom_range(0, 3) == 0) begin
                part = $urandom_range(1, len - 1);
                for (n = 0; n < part; n++) begin
                    queue_symbol(8'($urandom), pick_gap(calm));
                    items++;
                end
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || expected_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_codes.size() != 0) begin
            $error("%0d code symbols never arrived", expected_codes.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
rtl/core/rse_pkg.sv
rtl/core/rse_gen.sv
rtl/core/rse_core.sv
rtl/core/reed_solomon_encoder_top.sv
dv/tb_reed_solomon_encoder_top.sv
